// ===== rtl/lphj_pkg.sv =====
package lphj_pkg;

  localparam int KeyW   = 32;
  localparam int PayW   = 32;
  localparam int TotW   = 64;
  localparam int SbW    = 5;
  localparam int StatW  = 3;
  localparam int ReqW   = 2;
  localparam int ApbW   = 32;
  localparam int PaddrW = 2;

  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_PROBE  = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [ReqW-1:0] REQ_NONE   = 2'd3;

  localparam logic [StatW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatW-1:0] ST_ZERO_KEY = 3'd2;
  localparam logic [StatW-1:0] ST_HIT      = 3'd3;
  localparam logic [StatW-1:0] ST_MISS     = 3'd4;
  localparam logic [StatW-1:0] ST_CLEARED  = 3'd5;

  localparam logic [SbW-1:0] SLOT_BITS_RST = 5'd16;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic resolved;
    logic sweep_last;
  } stat_t;

endpackage

// ===== rtl/lphj_ram.sv =====
module lphj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lphj_ctrl.sv =====
module lphj_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [lphj_pkg::ReqW-1:0] req_type,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  lphj_pkg::stat_t           stat,
  output lphj_pkg::cmd_t            cmd
);

  lphj_pkg::state_t state, state_next;
  logic             out_busy;

  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lphj_pkg::S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lphj_pkg::S_INIT: begin
        if (stat.sweep_last) state_next = lphj_pkg::S_IDLE;
      end
      lphj_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (req_type) inside
            lphj_pkg::REQ_CLEAR:                      state_next = lphj_pkg::S_CLEAR;
            lphj_pkg::REQ_INSERT, lphj_pkg::REQ_PROBE: state_next = lphj_pkg::S_CHECK;
            default:                                  state_next = lphj_pkg::S_IDLE;
          endcase
        end
      end
      lphj_pkg::S_CLEAR: begin
        if (stat.sweep_last) state_next = lphj_pkg::S_CHECK;
      end
      lphj_pkg::S_CHECK: begin
        if (stat.resolved && !out_busy) state_next = lphj_pkg::S_IDLE;
      end
      default: state_next = lphj_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lphj_pkg::S_INIT: begin
        cmd.sweep = 1'b1;
      end
      lphj_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lphj_pkg::S_CLEAR: begin
        cmd.sweep = 1'b1;
      end
      lphj_pkg::S_CHECK: begin
        cmd.finish = stat.resolved && !out_busy;
        cmd.step   = !stat.resolved;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_busy)
    else $error("result loaded over an untaken word");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !in_ready)
    else $error("input taken during table sweep");

  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (state == lphj_pkg::S_INIT && stat.sweep_last) |=> state == lphj_pkg::S_IDLE)
    else $error("reset sweep did not end in idle");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("output valid without a finished item");

  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && (cmd.finish || cmd.accept || cmd.sweep)))
    else $error("probe step overlaps another command");

endmodule

// ===== rtl/lphj_dp.sv =====
module lphj_dp #(
  parameter int LOG_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lphj_pkg::cmd_t               cmd,
  output lphj_pkg::stat_t              stat,
  input  logic [lphj_pkg::ReqW-1:0]    req_type,
  input  logic [lphj_pkg::KeyW-1:0]    key,
  input  logic [lphj_pkg::PayW-1:0]    payload,
  output logic [lphj_pkg::StatW-1:0]   status,
  output logic [lphj_pkg::PayW-1:0]    found_value,
  output logic [lphj_pkg::TotW-1:0]    match_count,
  output logic [lphj_pkg::TotW-1:0]    running_checksum,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lphj_pkg::ApbW-1:0]    pwdata,
  output logic [lphj_pkg::ApbW-1:0]    prdata,
  output logic                         ram_we,
  output logic [LOG_SLOTS-1:0]         ram_waddr,
  output logic [lphj_pkg::KeyW+lphj_pkg::PayW-1:0] ram_wdata,
  output logic [LOG_SLOTS-1:0]         ram_raddr,
  input  logic [lphj_pkg::KeyW+lphj_pkg::PayW-1:0] ram_rdata
);

  logic [lphj_pkg::SbW-1:0]   slot_bits;
  logic [lphj_pkg::SbW-1:0]   k_eff;
  logic [LOG_SLOTS-1:0]       mask;
  logic [lphj_pkg::ReqW-1:0]  op;
  logic [lphj_pkg::KeyW-1:0]  key_q;
  logic [lphj_pkg::PayW-1:0]  pay_q;
  logic [LOG_SLOTS-1:0]       idx;
  logic [LOG_SLOTS-1:0]       steps;
  logic [LOG_SLOTS-1:0]       swp;
  logic [LOG_SLOTS-1:0]       home;
  logic [LOG_SLOTS-1:0]       idx_inc;
  logic [lphj_pkg::KeyW-1:0]  rkey;
  logic [lphj_pkg::PayW-1:0]  rval;
  logic                       zero_key;
  logic                       hit;
  logic                       empty;
  logic                       last;
  logic                       resolved;
  logic [lphj_pkg::StatW-1:0] res_status;
  logic                       do_insert;

  // config register, its low SbW bits read back as written and the upper bits read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bits <= lphj_pkg::SLOT_BITS_RST;
    end else if (psel && penable && pwrite) begin
      slot_bits <= pwdata[lphj_pkg::SbW-1:0];
    end
  end

  assign prdata = {{(lphj_pkg::ApbW-lphj_pkg::SbW){1'b0}}, slot_bits};

  always_comb begin
    k_eff = slot_bits;
    if (slot_bits == '0) k_eff = lphj_pkg::SbW'(1);
    else if (slot_bits > lphj_pkg::SbW'(LOG_SLOTS)) k_eff = lphj_pkg::SbW'(LOG_SLOTS);
  end

  assign mask    = ~({LOG_SLOTS{1'b1}} << k_eff);
  assign home    = key[LOG_SLOTS-1:0] & mask;
  assign idx_inc = (idx + 1'b1) & mask;
  assign rkey    = ram_rdata[lphj_pkg::KeyW+lphj_pkg::PayW-1:lphj_pkg::PayW];
  assign rval    = ram_rdata[lphj_pkg::PayW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= req_type;
      key_q <= key;
      pay_q <= payload;
      idx   <= home;
      steps <= '0;
    end else if (cmd.step) begin
      idx   <= idx_inc;
      steps <= steps + 1'b1;
    end
  end

  // sweep pointer wraps back to zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      swp <= '0;
    end else if (cmd.sweep) begin
      swp <= swp + 1'b1;
    end
  end

  assign stat = '{resolved: resolved, sweep_last: &swp};

  // next slot is read as the index advances, so its data arrives together with the new index
  always_comb begin
    if (cmd.accept)    ram_raddr = home;
    else if (cmd.step) ram_raddr = idx_inc;
    else               ram_raddr = idx;
  end

  assign zero_key = (key_q == '0);
  assign hit      = (rkey == key_q);
  assign empty    = (rkey == '0);
  assign last     = (steps == mask);

  always_comb begin
    resolved   = 1'b1;
    res_status = lphj_pkg::ST_MISS;
    case (op)
      lphj_pkg::REQ_CLEAR: begin
        res_status = lphj_pkg::ST_CLEARED;
      end
      lphj_pkg::REQ_INSERT: begin
        if (zero_key) begin
          res_status = lphj_pkg::ST_ZERO_KEY;
        end else begin
          resolved   = empty || last;
          res_status = empty ? lphj_pkg::ST_INSERTED : lphj_pkg::ST_FULL;
        end
      end
      lphj_pkg::REQ_PROBE: begin
        if (zero_key) begin
          res_status = lphj_pkg::ST_ZERO_KEY;
        end else begin
          resolved   = hit || empty || last;
          res_status = hit ? lphj_pkg::ST_HIT : lphj_pkg::ST_MISS;
        end
      end
      default: begin
        res_status = lphj_pkg::ST_MISS;
      end
    endcase
  end

  assign do_insert = cmd.finish && (res_status == lphj_pkg::ST_INSERTED);

  assign ram_we    = cmd.sweep || do_insert;
  assign ram_waddr = cmd.sweep ? swp : idx;
  assign ram_wdata = cmd.sweep ? '0 : {key_q, pay_q};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= res_status;
      found_value <= (res_status == lphj_pkg::ST_HIT) ? rval : '0;
    end
  end

  // totals only move when a result is loaded, so they double as output words
  always_ff @(posedge clk) begin
    if (rst) begin
      match_count      <= '0;
      running_checksum <= '0;
    end else if (cmd.finish) begin
      if (res_status == lphj_pkg::ST_CLEARED) begin
        match_count      <= '0;
        running_checksum <= '0;
      end else if (res_status == lphj_pkg::ST_HIT) begin
        match_count      <= match_count + 1'b1;
        running_checksum <= running_checksum + lphj_pkg::TotW'(pay_q)
                            + lphj_pkg::TotW'(rval);
      end
    end
  end

endmodule

// ===== rtl/linear_probe_hash_join.sv =====
// channel   signals                                   word
// in        in_valid, in_ready                        req_type, key, payload
// out       out_valid, out_ready                      status, found_value, match_count,
//                                                     running_checksum
// config    psel, penable, pwrite, paddr, pready      pwdata, prdata (slot_bits at 0x0)
//
// an item is accepted, then visits table slots from its home slot onward
// (one registered ram read per slot) until it resolves; zero key items
// resolve at their home slot
// a clear sweeps all 2**LOG_SLOTS slots, one per cycle, before its word
// after reset the same sweep runs over every slot with in_ready low
// a new item is taken while the previous word waits; the block stalls at
// resolution until the output register is free
module linear_probe_hash_join #(
  parameter int LOG_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lphj_pkg::ReqW-1:0]         req_type,
  input  logic [lphj_pkg::KeyW-1:0]         key,
  input  logic [lphj_pkg::PayW-1:0]         payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lphj_pkg::StatW-1:0]        status,
  output logic [lphj_pkg::PayW-1:0]         found_value,
  output logic [lphj_pkg::TotW-1:0]         match_count,
  output logic [lphj_pkg::TotW-1:0]         running_checksum,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lphj_pkg::PaddrW-1:0]       paddr,
  input  logic [lphj_pkg::ApbW-1:0]         pwdata,
  output logic [lphj_pkg::ApbW-1:0]         prdata,
  output logic                              pready
);

  localparam int DataW = lphj_pkg::KeyW + lphj_pkg::PayW;

  lphj_pkg::cmd_t  cmd;
  lphj_pkg::stat_t stat;
  logic                 ram_we;
  logic [LOG_SLOTS-1:0] ram_waddr;
  logic [DataW-1:0]     ram_wdata;
  logic [LOG_SLOTS-1:0] ram_raddr;
  logic [DataW-1:0]     ram_rdata;
  logic [lphj_pkg::ApbW-1:0] reg_rdata;

  assign pready = 1'b1;
  // single register, every offset in the word decodes to it
  assign prdata = (paddr[lphj_pkg::PaddrW-1:0] == '0) ? reg_rdata : reg_rdata;

  lphj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lphj_dp #(
    .LOG_SLOTS (LOG_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (req_type),
    .key              (key),
    .payload          (payload),
    .status           (status),
    .found_value      (found_value),
    .match_count      (match_count),
    .running_checksum (running_checksum),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pwdata           (pwdata),
    .prdata           (reg_rdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  lphj_ram #(
    .WIDTH (DataW),
    .DEPTH (2 ** LOG_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== tb/tb_linear_probe_hash_join.sv =====
`timescale 1ns / 100ps

module tb_linear_probe_hash_join;

  localparam int LOG_SLOTS = 16;
  localparam int SLOTS = 1 << LOG_SLOTS;
  localparam logic [lphj_pkg::PaddrW-1:0] ADDR_SLOT_BITS = '0;
  localparam int PHASE_WORDS = 143;
  localparam int SETTLE = 8;
  localparam int TAIL = 20;
  localparam int PRESSURE_AT = 680;
  localparam int PRESSURE_CYCLES = 500;

  typedef struct packed {
    logic [lphj_pkg::StatW-1:0] status;
    logic [lphj_pkg::PayW-1:0]  found;
    logic [lphj_pkg::TotW-1:0]  match_cnt;
    logic [lphj_pkg::TotW-1:0]  checksum;
  } join_word_t;

  class join_scoreboard;
    bit [lphj_pkg::KeyW-1:0] slot_key [SLOTS];
    bit [lphj_pkg::PayW-1:0] slot_val [SLOTS];
    bit [lphj_pkg::SbW-1:0]  slot_bits;
    bit [16:0]               fills;
    bit [lphj_pkg::TotW-1:0] hits;
    bit [lphj_pkg::TotW-1:0] sums;
    join_word_t              pending_words [$];
    int                      errors;

    function new();
      slot_bits = lphj_pkg::SLOT_BITS_RST;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      fills = '0;
      hits = '0;
      sums = '0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // work out the word an accepted request will produce
    function void note_word(logic [lphj_pkg::ReqW-1:0] req, logic [lphj_pkg::KeyW-1:0] k,
                            logic [lphj_pkg::PayW-1:0] p);
      join_word_t w;
      bit [31:0] mask;
      bit [31:0] h;
      int eff;
      int steps;
      if (req == lphj_pkg::REQ_NONE) return;
      eff = slot_bits;
      if (eff < 1) eff = 1;
      if (eff > LOG_SLOTS) eff = LOG_SLOTS;
      mask = (32'd1 << eff) - 32'd1;
      w.found = '0;
      if (req == lphj_pkg::REQ_CLEAR) begin
        wipe();
        w.status = lphj_pkg::ST_CLEARED;
      end else if (k == '0) begin
        w.status = lphj_pkg::ST_ZERO_KEY;
      end else if (req == lphj_pkg::REQ_INSERT) begin
        w.status = lphj_pkg::ST_FULL;
        h = k & mask;
        for (steps = 0; steps <= int'(mask); steps++) begin
          if (slot_key[h] == '0) begin
            slot_key[h] = k;
            slot_val[h] = p;
            fills++;
            w.status = lphj_pkg::ST_INSERTED;
            break;
          end
          h = (h + 1) & mask;
        end
      end else begin
        // one full pass at most, even with no empty slot in the table
        w.status = lphj_pkg::ST_MISS;
        h = k & mask;
        for (steps = 0; steps <= int'(mask); steps++) begin
          if (slot_key[h] == k) begin
            w.found = slot_val[h];
            hits++;
            sums += {32'd0, p} + {32'd0, w.found};
            w.status = lphj_pkg::ST_HIT;
            break;
          end
          if (slot_key[h] == '0) break;
          h = (h + 1) & mask;
        end
      end
      w.match_cnt = hits;
      w.checksum = sums;
      pending_words.push_back(w);
    endfunction

    function void check_word(join_word_t got);
      join_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: word with nothing pending, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found_value expected %h got %h", $time, want.found, got.found);
        errors++;
      end
      if (got.match_cnt !== want.match_cnt) begin
        $display("%0t: match_count expected %0d got %0d", $time, want.match_cnt,
                 got.match_cnt);
        errors++;
      end
      if (got.checksum !== want.checksum) begin
        $display("%0t: running_checksum expected %h got %h", $time, want.checksum,
                 got.checksum);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [lphj_pkg::ReqW-1:0] req_type;
  logic [lphj_pkg::KeyW-1:0] key;
  logic [lphj_pkg::PayW-1:0] payload;
  logic out_valid;
  logic out_ready;
  logic [lphj_pkg::StatW-1:0] status;
  logic [lphj_pkg::PayW-1:0] found_value;
  logic [lphj_pkg::TotW-1:0] match_count;
  logic [lphj_pkg::TotW-1:0] running_checksum;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lphj_pkg::PaddrW-1:0] paddr;
  logic [lphj_pkg::ApbW-1:0] pwdata;
  logic [lphj_pkg::ApbW-1:0] prdata;
  logic pready;
  logic hold_off = 1'b0;

  join_scoreboard sb;
  int words_in = 0;
  int tx_quiet = 0;
  int rx_quiet = 0;
  bit [lphj_pkg::KeyW-1:0] live_keys [$];
  bit [lphj_pkg::SbW-1:0] phase_bits [10] = '{5'd3, 5'd16, 5'd1, 5'd8, 5'd0, 5'd5, 5'd31,
                                              5'd2, 5'd12, 5'd4};

  linear_probe_hash_join #(.LOG_SLOTS(LOG_SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .key(key),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_value(found_value),
    .match_count(match_count),
    .running_checksum(running_checksum),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [lphj_pkg::KeyW-1:0] fresh_key();
    bit [lphj_pkg::KeyW-1:0] k;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) k = ~32'($urandom_range(0, 3));
    else if (r < 4) k = ($urandom << 16) | $urandom_range(0, 7);
    else k = $urandom;
    if (k == '0) k = 32'd1;
    return k;
  endfunction

  function automatic bit [lphj_pkg::KeyW-1:0] pool_key();
    return live_keys[$urandom_range(0, live_keys.size() - 1)];
  endfunction

  function automatic bit [lphj_pkg::PayW-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_word(input logic [lphj_pkg::ReqW-1:0] req,
                           input logic [lphj_pkg::KeyW-1:0] k,
                           input logic [lphj_pkg::PayW-1:0] p);
    int g;
    g = idle_len(tx_quiet);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    key <= k;
    payload <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(req, k, p);
    words_in++;
  endtask

  // register write only once the block has drained, then read it back
  task automatic set_slot_bits(input logic [lphj_pkg::SbW-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SLOT_BITS;
    pwdata <= ($urandom & ~32'h1F) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.slot_bits = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[lphj_pkg::SbW-1:0] !== v) begin
      $display("%0t: slot_bits read expected %0d got %0d", $time, v,
               prdata[lphj_pkg::SbW-1:0]);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side
  initial begin
    join_word_t got;
    int hi;
    int lo;
    int i;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      hi = $urandom_range(1, 16);
      lo = idle_len(rx_quiet);
      for (i = 0; i < hi + lo; i++) begin
        out_ready <= (i < hi) && !hold_off;
        @(posedge clk);
        if (!rst && out_valid && out_ready) begin
          got = {status, found_value, match_count, running_checksum};
          sb.check_word(got);
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (words_in < PRESSURE_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(80_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int r;
    int clears_left;
    bit [lphj_pkg::KeyW-1:0] k;
    logic [lphj_pkg::ReqW-1:0] req;
    sb = new();
    clears_left = 2;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= lphj_pkg::REQ_NONE;
    key <= '0;
    payload <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SLOT_BITS;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // table sweep after reset
    while (!in_ready) @(posedge clk);

    // full table size: collisions, duplicates, wrap at the top slot
    send_word(lphj_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lphj_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0000);
    send_word(lphj_pkg::REQ_INSERT, 32'h0001_0001, 32'h1234_5678);
    send_word(lphj_pkg::REQ_INSERT, 32'h0000_0001, 32'hA5A5_A5A5);
    send_word(lphj_pkg::REQ_INSERT, 32'h0002_FFFF, 32'h0000_0007);
    send_word(lphj_pkg::REQ_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
    send_word(lphj_pkg::REQ_PROBE, 32'h0000_0000, 32'h0000_0001);
    send_word(lphj_pkg::REQ_PROBE, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(lphj_pkg::REQ_PROBE, 32'h0001_0001, 32'h0000_0001);
    send_word(lphj_pkg::REQ_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lphj_pkg::REQ_PROBE, 32'h0002_FFFF, 32'h0000_0000);
    send_word(lphj_pkg::REQ_PROBE, 32'h0000_0002, 32'h0000_0005);
    send_word(lphj_pkg::REQ_PROBE, 32'h8000_0000, 32'h8000_0000);
    send_word(lphj_pkg::REQ_NONE, 32'h0000_0005, 32'h0000_0005);
    send_word(lphj_pkg::REQ_CLEAR, 32'h0000_0000, 32'h0000_0000);

    // two slots: full table and a probe that gives up
    set_slot_bits(5'd1);
    send_word(lphj_pkg::REQ_INSERT, 32'd2, 32'h0000_0011);
    send_word(lphj_pkg::REQ_INSERT, 32'd3, 32'h0000_0022);
    send_word(lphj_pkg::REQ_INSERT, 32'd5, 32'h0000_0033);
    send_word(lphj_pkg::REQ_PROBE, 32'd7, 32'h0000_0001);
    send_word(lphj_pkg::REQ_PROBE, 32'd3, 32'h0000_0001);
    set_slot_bits(5'd0);
    send_word(lphj_pkg::REQ_INSERT, 32'd4, 32'h0000_0044);
    send_word(lphj_pkg::REQ_PROBE, 32'd2, 32'h0000_0002);
    // saturates to the full size, old entries stay where they were
    set_slot_bits(5'd31);
    send_word(lphj_pkg::REQ_PROBE, 32'd2, 32'h0000_0001);
    send_word(lphj_pkg::REQ_INSERT, 32'h0001_0000, 32'h0000_0055);
    send_word(lphj_pkg::REQ_PROBE, 32'h0001_0000, 32'h0000_0003);

    for (ph = 0; ph < 10; ph++) begin
      set_slot_bits(phase_bits[ph]);
      if (ph % 2 == 1) begin
        send_word(lphj_pkg::REQ_CLEAR, $urandom, $urandom);
        live_keys.delete();
      end
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (clears_left > 0 && $urandom_range(0, 399) == 0) begin
          send_word(lphj_pkg::REQ_CLEAR, $urandom, $urandom);
          live_keys.delete();
          clears_left--;
          n++;
        end else if (r < 2) begin
          send_word(lphj_pkg::REQ_NONE, $urandom, $urandom);
        end else if (r < 7) begin
          req = ($urandom_range(0, 1) != 0) ? lphj_pkg::REQ_PROBE : lphj_pkg::REQ_INSERT;
          send_word(req, '0, pick_payload());
          n++;
        end else if (r < 50) begin
          k = (live_keys.size() != 0 && $urandom_range(0, 9) == 0) ? pool_key() : fresh_key();
          send_word(lphj_pkg::REQ_INSERT, k, pick_payload());
          if (live_keys.size() < 256) live_keys.push_back(k);
          else live_keys[$urandom_range(0, 255)] = k;
          n++;
        end else begin
          k = (live_keys.size() != 0 && $urandom_range(0, 9) < 7) ? pool_key() : fresh_key();
          send_word(lphj_pkg::REQ_PROBE, k, pick_payload());
          n++;
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
